/* hw/rtl/lmsp_pkg.sv */
package lmsp_pkg;

  localparam int unsigned NumTaps  = 4;
  localparam int unsigned MaxDelay = 16;
  localparam int unsigned TapRegs  = 4;

  localparam int unsigned SmpW    = 16;
  localparam int unsigned ErrW    = 17;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned StepW   = 16;
  localparam int unsigned DlyW    = 5;
  localparam int unsigned IdxW    = 32;
  localparam int unsigned DataW   = 32;
  localparam int unsigned PaddrW  = 5;

  localparam int unsigned TapIdxW = (NumTaps > 1) ? $clog2(NumTaps) : 1;
  localparam int unsigned PtrW    = (MaxDelay > 1) ? $clog2(MaxDelay) : 1;
  // Wide enough for any delay register value and for MaxDelay itself.
  localparam int unsigned DlyCmpW = 7;
  localparam int unsigned SeqCntW = $clog2(NumTaps + 2);

  localparam int unsigned ProdW = CoefW + SmpW;
  localparam int unsigned AccW  = ProdW + TapIdxW;
  localparam int unsigned MuW   = StepW + 1 + ErrW;
  localparam int unsigned UpdW  = MuW + SmpW;

  localparam int unsigned EstShift = 20;
  localparam int unsigned UpdShift = 26;

  typedef enum logic [2:0] {
    RegStepSize  = 3'd0,
    RegTap0Delay = 3'd1,
    RegTap1Delay = 3'd2,
    RegTap2Delay = 3'd3,
    RegTap3Delay = 3'd4
  } reg_idx_e;

  typedef logic [TapRegs-1:0][DlyW-1:0] tap_delay_t;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMac  = 6'b000010,
    StEst  = 6'b000100,
    StMu   = 6'b001000,
    StUpd  = 6'b010000,
    StFin  = 6'b100000
  } lmsp_state_e;

  typedef struct packed {
    logic               start;
    logic               rd_en;
    logic [TapIdxW-1:0] rd_tap;
    logic               mul_en;
    logic [TapIdxW-1:0] mul_tap;
    logic               acc_en;
    logic               est_en;
    logic               mu_en;
    logic               umul_en;
    logic [TapIdxW-1:0] umul_tap;
    logic               upd_en;
    logic [TapIdxW-1:0] upd_tap;
    logic               fin_en;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

/* hw/rtl/lmsp_ram.sv */
module lmsp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/lmsp_regs.sv */
module lmsp_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lmsp_pkg::PaddrW-1:0] paddr,
  input  logic [lmsp_pkg::DataW-1:0]  pwdata,
  output logic [lmsp_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output logic [lmsp_pkg::StepW-1:0]  step_size_o,
  output lmsp_pkg::tap_delay_t        tap_delay_o
);
  import lmsp_pkg::*;

  logic [StepW-1:0] step_q;
  tap_delay_t       tap_q;
  reg_idx_e         idx;
  logic             wr;

  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      for (int k = 0; k < TapRegs; k++) begin
        tap_q[k] <= DlyW'(k + 1);
      end
    end else if (wr) begin
      unique case (idx)
        RegStepSize:  step_q   <= pwdata[StepW-1:0];
        RegTap0Delay: tap_q[0] <= pwdata[DlyW-1:0];
        RegTap1Delay: tap_q[1] <= pwdata[DlyW-1:0];
        RegTap2Delay: tap_q[2] <= pwdata[DlyW-1:0];
        RegTap3Delay: tap_q[3] <= pwdata[DlyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegStepSize:  prdata = DataW'(step_q);
      RegTap0Delay: prdata = DataW'(tap_q[0]);
      RegTap1Delay: prdata = DataW'(tap_q[1]);
      RegTap2Delay: prdata = DataW'(tap_q[2]);
      RegTap3Delay: prdata = DataW'(tap_q[3]);
      default:      prdata = '0;
    endcase
  end

  assign step_size_o = step_q;
  assign tap_delay_o = tap_q;

endmodule

/* hw/rtl/lmsp_ctrl.sv */
module lmsp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lmsp_pkg::dp_status_t status_i,
  output lmsp_pkg::dp_cmd_t    cmd_o
);
  import lmsp_pkg::*;

  localparam logic [SeqCntW-1:0] CntTaps    = SeqCntW'(NumTaps);
  localparam logic [SeqCntW-1:0] CntMacLast = SeqCntW'(NumTaps + 1);
  localparam logic [SeqCntW-1:0] CntOne     = SeqCntW'(1);
  localparam logic [SeqCntW-1:0] CntTwo     = SeqCntW'(2);

  lmsp_state_e        state_q, state_d;
  logic [SeqCntW-1:0] cnt_q, cnt_d;
  logic [SeqCntW-1:0] cnt_m1;

  assign cnt_m1 = cnt_q - CntOne;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.rd_tap   = cnt_q[TapIdxW-1:0];
    cmd_o.mul_tap  = cnt_m1[TapIdxW-1:0];
    cmd_o.umul_tap = cnt_q[TapIdxW-1:0];
    cmd_o.upd_tap  = cnt_m1[TapIdxW-1:0];
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = StMac;
        end
      end
      StMac: begin
        cmd_o.rd_en  = (cnt_q < CntTaps);
        cmd_o.mul_en = (cnt_q >= CntOne) && (cnt_q <= CntTaps);
        cmd_o.acc_en = (cnt_q >= CntTwo);
        if (cnt_q == CntMacLast) begin
          cnt_d   = '0;
          state_d = StEst;
        end else begin
          cnt_d = cnt_q + CntOne;
        end
      end
      StEst: begin
        cmd_o.est_en = 1'b1;
        state_d      = StMu;
      end
      StMu: begin
        cmd_o.mu_en = 1'b1;
        cnt_d       = '0;
        state_d     = StUpd;
      end
      StUpd: begin
        cmd_o.umul_en = (cnt_q < CntTaps);
        cmd_o.upd_en  = (cnt_q >= CntOne);
        if (cnt_q == CntTaps) begin
          cnt_d   = '0;
          state_d = StFin;
        end else begin
          cnt_d = cnt_q + CntOne;
        end
      end
      StFin: begin
        if (status_i.out_free) begin
          cmd_o.fin_en = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

/* hw/rtl/lmsp_dp.sv */
module lmsp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [lmsp_pkg::SmpW-1:0]  sample_in_i,
  input  logic        [lmsp_pkg::StepW-1:0] step_size_i,
  input  lmsp_pkg::tap_delay_t              tap_delay_i,
  input  lmsp_pkg::dp_cmd_t                 cmd_i,
  output lmsp_pkg::dp_status_t              status_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic        [lmsp_pkg::IdxW-1:0]  sample_index_o,
  output logic signed [lmsp_pkg::SmpW-1:0]  sample_echo_o,
  output logic signed [lmsp_pkg::SmpW-1:0]  estimate_o,
  output logic signed [lmsp_pkg::ErrW-1:0]  pred_error_o,
  output logic signed [lmsp_pkg::CoefW-1:0] coef_0_o,
  output logic signed [lmsp_pkg::CoefW-1:0] coef_1_o,
  output logic signed [lmsp_pkg::CoefW-1:0] coef_2_o,
  output logic signed [lmsp_pkg::CoefW-1:0] coef_3_o
);
  import lmsp_pkg::*;

  localparam logic signed [AccW-1:0]  EstHalf = AccW'(1) << (EstShift - 1);
  localparam logic signed [AccW-1:0]  EstMax  = AccW'((1 << (SmpW - 1)) - 1);
  localparam logic signed [AccW-1:0]  EstMin  = -EstMax - AccW'(1);
  localparam logic signed [UpdW-1:0]  UpdHalf = UpdW'(1) << (UpdShift - 1);
  localparam logic signed [UpdW-1:0]  CoefMax = UpdW'((1 << (CoefW - 1)) - 1);
  localparam logic signed [UpdW-1:0]  CoefMin = -CoefMax - UpdW'(1);
  localparam logic [DlyCmpW-1:0]      DlyOne  = DlyCmpW'(1);
  localparam logic [DlyCmpW-1:0]      DlyMax  = DlyCmpW'(MaxDelay);
  localparam logic [PtrW-1:0]         PtrLast = PtrW'(MaxDelay - 1);

  logic signed [SmpW-1:0]  sample_q;
  logic [PtrW-1:0]         wp_q;
  logic [MaxDelay-1:0]     hist_valid_q;
  logic                    hv_rd_q;
  logic [IdxW-1:0]         count_q;
  logic signed [CoefW-1:0] coef_q [NumTaps];
  logic signed [SmpW-1:0]  hist_lane_q [NumTaps];
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [SmpW-1:0]  est_q;
  logic signed [ErrW-1:0]  err_q;
  logic signed [MuW-1:0]   mu_q;
  logic signed [UpdW-1:0]  prod2_q;
  logic                    out_valid_q;
  logic [IdxW-1:0]         out_idx_q;
  logic signed [SmpW-1:0]  out_echo_q;
  logic signed [SmpW-1:0]  out_est_q;
  logic signed [ErrW-1:0]  out_err_q;
  logic signed [CoefW-1:0] out_coef_q [TapRegs];

  logic [DlyW-1:0]         dly_used [NumTaps];
  logic signed [CoefW-1:0] coef_full [TapRegs];
  logic [DlyCmpW-1:0]      dly_raw, dly_eff, wp_ext, addr_ext;
  logic [PtrW-1:0]         raddr;
  logic [SmpW-1:0]         ram_rdata;
  logic signed [SmpW-1:0]  hist_val;
  logic signed [AccW-1:0]  est_rnd, est_sh;
  logic signed [SmpW-1:0]  est_sat;
  logic signed [ErrW-1:0]  err_val;
  logic signed [UpdW-1:0]  upd_rnd, upd_sh, coef_sum;
  logic signed [CoefW-1:0] coef_sat;

  for (genvar k = 0; k < NumTaps; k++) begin : g_dly
    assign dly_used[k] = tap_delay_i[k];
  end

  for (genvar k = 0; k < TapRegs; k++) begin : g_coef
    if (k < NumTaps) begin : g_used
      assign coef_full[k] = coef_q[k];
    end else begin : g_unused
      assign coef_full[k] = '0;
    end
  end

  // A delay of zero reads as one and a delay beyond the line reads its oldest entry.
  always_comb begin
    dly_raw = DlyCmpW'(dly_used[cmd_i.rd_tap]);
    if (dly_raw == '0) begin
      dly_eff = DlyOne;
    end else if (dly_raw > DlyMax) begin
      dly_eff = DlyMax;
    end else begin
      dly_eff = dly_raw;
    end
    wp_ext = DlyCmpW'(wp_q);
    if (wp_ext >= dly_eff) begin
      addr_ext = wp_ext - dly_eff;
    end else begin
      addr_ext = wp_ext + DlyMax - dly_eff;
    end
    raddr = addr_ext[PtrW-1:0];
  end

  lmsp_ram #(
    .Width (SmpW),
    .Depth (MaxDelay)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fin_en),
    .waddr_i (wp_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign hist_val = hv_rd_q ? $signed(ram_rdata) : '0;

  always_comb begin
    est_rnd = acc_q + EstHalf;
    est_sh  = est_rnd >>> EstShift;
    if (est_sh > EstMax) begin
      est_sat = EstMax[SmpW-1:0];
    end else if (est_sh < EstMin) begin
      est_sat = EstMin[SmpW-1:0];
    end else begin
      est_sat = est_sh[SmpW-1:0];
    end
    err_val = ErrW'(sample_q) - ErrW'(est_sat);
  end

  always_comb begin
    upd_rnd  = prod2_q + UpdHalf;
    upd_sh   = upd_rnd >>> UpdShift;
    coef_sum = UpdW'(coef_q[cmd_i.upd_tap]) + upd_sh;
    if (coef_sum > CoefMax) begin
      coef_sat = CoefMax[CoefW-1:0];
    end else if (coef_sum < CoefMin) begin
      coef_sat = CoefMin[CoefW-1:0];
    end else begin
      coef_sat = coef_sum[CoefW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      hist_valid_q <= '0;
      hv_rd_q      <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < NumTaps; k++) begin
        coef_q[k] <= '0;
      end
    end else begin
      if (cmd_i.rd_en) begin
        hv_rd_q <= hist_valid_q[raddr];
      end
      if (cmd_i.upd_en) begin
        coef_q[cmd_i.upd_tap] <= coef_sat;
      end
      if (cmd_i.fin_en) begin
        hist_valid_q[wp_q] <= 1'b1;
        wp_q               <= (wp_q == PtrLast) ? '0 : wp_q + PtrW'(1);
        count_q            <= count_q + IdxW'(1);
        out_valid_q        <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sample_q <= sample_in_i;
      acc_q    <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    if (cmd_i.mul_en) begin
      prod_q                   <= coef_q[cmd_i.mul_tap] * hist_val;
      hist_lane_q[cmd_i.mul_tap] <= hist_val;
    end
    if (cmd_i.est_en) begin
      est_q <= est_sat;
      err_q <= err_val;
    end
    if (cmd_i.mu_en) begin
      mu_q <= $signed({1'b0, step_size_i}) * err_q;
    end
    if (cmd_i.umul_en) begin
      prod2_q <= mu_q * hist_lane_q[cmd_i.umul_tap];
    end
    if (cmd_i.fin_en) begin
      out_idx_q  <= count_q;
      out_echo_q <= sample_q;
      out_est_q  <= est_q;
      out_err_q  <= err_q;
      for (int k = 0; k < TapRegs; k++) begin
        out_coef_q[k] <= coef_full[k];
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign sample_index_o = out_idx_q;
  assign sample_echo_o  = out_echo_q;
  assign estimate_o     = out_est_q;
  assign pred_error_o   = out_err_q;
  assign coef_0_o       = out_coef_q[0];
  assign coef_1_o       = out_coef_q[1];
  assign coef_2_o       = out_coef_q[2];
  assign coef_3_o       = out_coef_q[3];

endmodule

/* hw/rtl/lms_sparse_tap_predictor.sv */
// Adaptive linear predictor with configurable sparse taps, trained by LMS. Each accepted
// sample yields one result holding the running sample index, the sample itself, the
// estimate made with the coefficients as they stood before the transfer, the prediction
// error and the coefficients after their update. For each sample the taps are visited one
// at a time, first through the history memory read port and the multiply-accumulate
// stage for the estimate, then through the update multiplier for the coefficients. A
// finished result waits in an output register and does not hold up the next input
// transfer; only the final write-back of a second sample waits for it to be taken.
// History and coefficients read as zero after reset, with no clearing pass.
// Configuration is written through the APB port; the user must write it only while
// the block is idle, and the block itself does not enforce this.
module lms_sparse_tap_predictor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic        [lmsp_pkg::PaddrW-1:0] paddr,
  input  logic        [lmsp_pkg::DataW-1:0] pwdata,
  output logic        [lmsp_pkg::DataW-1:0] prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [lmsp_pkg::SmpW-1:0]  sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic        [lmsp_pkg::IdxW-1:0]  sample_index_o,
  output logic signed [lmsp_pkg::SmpW-1:0]  sample_echo_o,
  output logic signed [lmsp_pkg::SmpW-1:0]  estimate_o,
  output logic signed [lmsp_pkg::ErrW-1:0]  pred_error_o,
  output logic signed [lmsp_pkg::CoefW-1:0] coef_0_o,
  output logic signed [lmsp_pkg::CoefW-1:0] coef_1_o,
  output logic signed [lmsp_pkg::CoefW-1:0] coef_2_o,
  output logic signed [lmsp_pkg::CoefW-1:0] coef_3_o
);
  import lmsp_pkg::*;

  logic [StepW-1:0] step_size;
  tap_delay_t       tap_delay;
  dp_cmd_t          cmd;
  dp_status_t       status;

  lmsp_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .step_size_o (step_size),
    .tap_delay_o (tap_delay)
  );

  lmsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lmsp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_in_i    (sample_in_i),
    .step_size_i    (step_size),
    .tap_delay_i    (tap_delay),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .sample_index_o (sample_index_o),
    .sample_echo_o  (sample_echo_o),
    .estimate_o     (estimate_o),
    .pred_error_o   (pred_error_o),
    .coef_0_o       (coef_0_o),
    .coef_1_o       (coef_1_o),
    .coef_2_o       (coef_2_o),
    .coef_3_o       (coef_3_o)
  );

  a_busy_after_transfer: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o
  ) else $error("input accepted again straight after a transfer");

  a_result_from_writeback: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.fin_en)
  ) else $error("result presented without a write-back");

  a_error_consistent: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pred_error_o == ($signed({sample_echo_o[SmpW-1], sample_echo_o})
                                    - $signed({estimate_o[SmpW-1], estimate_o})))
  ) else $error("prediction error does not match sample minus estimate");

endmodule
